// ===== design/btq_pkg.sv =====
package btq_pkg;

  localparam int NUM_BUTTONS_DEF = 9;
  localparam int COUNT_WIDTH_DEF = 8;
  localparam int KEY_W           = 9;
  localparam int IDX_W           = 4;
  localparam int KIND_W          = 2;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DOWN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UP   = 2'd2;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_POLL   = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  index;
    logic              pressed;
  } event_t;

endpackage

// ===== design/btq_tracker.sv =====
module btq_tracker #(
  parameter int NUM_BUTTONS = btq_pkg::NUM_BUTTONS_DEF,
  parameter int COUNT_WIDTH = btq_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  logic                   mode,
  input  logic [NUM_BUTTONS-1:0] levels,
  output btq_pkg::event_t        ev
);

  logic [NUM_BUTTONS-1:0] cur_r, cur_nxt;
  logic [NUM_BUTTONS-1:0] rep_r, rep_nxt;
  logic [COUNT_WIDTH-1:0] up_r   [NUM_BUTTONS];
  logic [COUNT_WIDTH-1:0] up_nxt [NUM_BUTTONS];
  logic [COUNT_WIDTH-1:0] dn_r   [NUM_BUTTONS];
  logic [COUNT_WIDTH-1:0] dn_nxt [NUM_BUTTONS];

  logic [NUM_BUTTONS-1:0] changed;
  logic [NUM_BUTTONS-1:0] elig;
  logic [NUM_BUTTONS-1:0] pick;
  logic                   found;

  always_comb begin
    changed = levels ^ cur_r;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      elig[i] = rep_r[i] ? (up_r[i] != '0) : (dn_r[i] != '0);
    end
    pick  = '0;
    found = 1'b0;
    ev    = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (elig[i] && !found) begin
        found    = 1'b1;
        pick[i]  = 1'b1;
        ev.index = btq_pkg::IDX_W'(i);
        ev.kind  = rep_r[i] ? btq_pkg::KIND_UP : btq_pkg::KIND_DOWN;
      end
    end
    if (mode == btq_pkg::MODE_SAMPLE) begin
      ev = '0;
    end
    ev.pressed = (ev.kind == btq_pkg::KIND_DOWN);
  end

  always_comb begin
    cur_nxt = cur_r;
    rep_nxt = rep_r;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      up_nxt[i] = up_r[i];
      dn_nxt[i] = dn_r[i];
    end
    if (go) begin
      if (mode == btq_pkg::MODE_SAMPLE) begin
        cur_nxt = levels;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          if (changed[i]) begin
            if (cur_r[i]) begin
              up_nxt[i] = up_r[i] + 1'b1;
            end else begin
              dn_nxt[i] = dn_r[i] + 1'b1;
            end
          end
        end
      end else begin
        rep_nxt = rep_r ^ pick;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          if (pick[i]) begin
            if (rep_r[i]) begin
              up_nxt[i] = up_r[i] - 1'b1;
            end else begin
              dn_nxt[i] = dn_r[i] - 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      rep_r <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        up_r[i] <= '0;
        dn_r[i] <= '0;
      end
    end else begin
      cur_r <= cur_nxt;
      rep_r <= rep_nxt;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        up_r[i] <= up_nxt[i];
        dn_r[i] <= dn_nxt[i];
      end
    end
  end

endmodule

// ===== design/button_transition_event_queue.sv =====
// The input transfer loads the input register; its result then goes to the result register.
// Throughput: one item per cycle when out_ready allows; the tracker steps once per item.
// The input side keeps accepting while a result waits, until both registers are full.
// Reset (rst_n low, synchronous) clears levels, reported levels, all pending
// counters and both valid flags.
module button_transition_event_queue #(
  parameter int NUM_BUTTONS = btq_pkg::NUM_BUTTONS_DEF,
  parameter int COUNT_WIDTH = btq_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic [btq_pkg::KEY_W-1:0]    in_key_levels,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [btq_pkg::KIND_W-1:0]   out_event_kind,
  output logic [btq_pkg::IDX_W-1:0]    out_button_index,
  output logic                         out_pressed
);

  logic                              in_vld_r;
  logic                              mode_r;
  logic [btq_pkg::KEY_W-1:0]         keys_r;
  logic                              out_vld_r;
  btq_pkg::event_t                   ev_r;
  btq_pkg::event_t                   ev;
  logic                              advance;
  logic                              go;
  logic [btq_pkg::KEY_W+NUM_BUTTONS-1:0] keys_ext;
  logic [NUM_BUTTONS-1:0]            levels;

  assign advance  = !out_vld_r || out_ready;
  assign go       = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;

  assign keys_ext = {{NUM_BUTTONS{1'b0}}, keys_r};
  assign levels   = keys_ext[NUM_BUTTONS-1:0];

  btq_tracker #(
    .NUM_BUTTONS(NUM_BUTTONS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .mode   (mode_r),
    .levels (levels),
    .ev     (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      keys_r <= in_key_levels;
    end
    if (go) begin
      ev_r <= ev;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_event_kind   = ev_r.kind;
  assign out_button_index = ev_r.index;
  assign out_pressed      = ev_r.pressed;

`ifndef ASSERT_OFF
  a_pressed_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pressed == (out_event_kind == btq_pkg::KIND_DOWN)))
    else $error("pressed flag disagrees with event kind");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_kind == btq_pkg::KIND_NONE ||
                   out_event_kind == btq_pkg::KIND_DOWN ||
                   out_event_kind == btq_pkg::KIND_UP))
    else $error("illegal event kind");

  a_none_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == btq_pkg::KIND_NONE) |-> (out_button_index == '0))
    else $error("no-event result with nonzero index");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");
`endif

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = btq_pkg::NUM_BUTTONS_DEF;
  localparam int CW = btq_pkg::COUNT_WIDTH_DEF;
  localparam int KW = btq_pkg::KEY_W;
  localparam int IW = btq_pkg::IDX_W;

  class event_scoreboard;
    bit [NB-1:0]     level_now;
    bit [NB-1:0]     level_told;
    bit [CW-1:0]     rise_cnt[NB];
    bit [CW-1:0]     fall_cnt[NB];
    btq_pkg::event_t expected_q[$];
    int unsigned     errors;

    function new();
      level_now  = '0;
      level_told = '0;
      foreach (rise_cnt[i]) begin
        rise_cnt[i] = '0;
        fall_cnt[i] = '0;
      end
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function btq_pkg::event_t next_event(logic mode, logic [KW-1:0] keys);
      btq_pkg::event_t ev;
      bit [NB-1:0]     moved;
      bit              hit;
      ev  = '0;
      hit = 1'b0;
      if (mode == btq_pkg::MODE_SAMPLE) begin
        moved = keys[NB-1:0] ^ level_now;
        for (int i = 0; i < NB; i++) begin
          if (moved[i]) begin
            if (level_now[i]) fall_cnt[i] = fall_cnt[i] + 1'b1;
            else rise_cnt[i] = rise_cnt[i] + 1'b1;
          end
        end
        level_now = keys[NB-1:0];
      end else begin
        for (int i = 0; i < NB; i++) begin
          if (!hit) begin
            if (level_told[i] && fall_cnt[i] != 0) begin
              fall_cnt[i]   = fall_cnt[i] - 1'b1;
              level_told[i] = 1'b0;
              ev.kind       = btq_pkg::KIND_UP;
              ev.index      = IW'(i);
              hit           = 1'b1;
            end else if (!level_told[i] && rise_cnt[i] != 0) begin
              rise_cnt[i]   = rise_cnt[i] - 1'b1;
              level_told[i] = 1'b1;
              ev.kind       = btq_pkg::KIND_DOWN;
              ev.index      = IW'(i);
              ev.pressed    = 1'b1;
              hit           = 1'b1;
            end
          end
        end
      end
      return ev;
    endfunction

    function void note_input(logic mode, logic [KW-1:0] keys);
      expected_q.push_back(next_event(mode, keys));
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [btq_pkg::KIND_W-1:0] kind, logic [IW-1:0] idx, logic pr);
      btq_pkg::event_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind=%0d index=%0d pressed=%0d", kind, idx, pr));
        return;
      end
      want = expected_q.pop_front();
      if (kind !== want.kind)
        report($sformatf("event_kind got %0d want %0d", kind, want.kind));
      if (idx !== want.index)
        report($sformatf("button_index got %0d want %0d", idx, want.index));
      if (pr !== want.pressed)
        report($sformatf("pressed got %0d want %0d", pr, want.pressed));
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_mode;
  logic [KW-1:0]                in_key_levels;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [btq_pkg::KIND_W-1:0]   out_event_kind;
  logic [IW-1:0]                out_button_index;
  logic                         out_pressed;

  event_scoreboard sb = new();
  bit              quiet = 1'b0;
  int              stall_left = 0;
  logic [KW-1:0]   levels = '0;

  button_transition_event_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_key_levels    (in_key_levels),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_button_index (out_button_index),
    .out_pressed      (out_pressed)
  );

  always #5 clk = ~clk;

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task send_item(logic mode, logic [KW-1:0] keys);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_key_levels <= keys;
    do @(posedge clk); while (!in_ready);
    sb.note_input(mode, keys);
  endtask

  task send_sample(logic [KW-1:0] keys);
    levels = keys;
    send_item(btq_pkg::MODE_SAMPLE, keys);
  endtask

  task send_poll();
    send_item(btq_pkg::MODE_POLL, KW'($urandom_range(0, 511)));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result(out_event_kind, out_button_index, out_pressed);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left = stall_left - 1;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        out_ready <= 1'b0;
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(4, 30);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int r;
    int b;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_mode       <= btq_pkg::MODE_SAMPLE;
    in_key_levels <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // nothing pending, then all rise and all fall, then priority order
    send_poll();
    send_sample(9'h000);
    send_sample(9'h1FF);
    send_poll();
    send_poll();
    send_sample(9'h000);
    send_poll();
    send_poll();
    send_poll();
    send_poll();
    send_sample(9'h100);
    send_sample(9'h000);
    send_sample(9'h100);
    send_item(btq_pkg::MODE_POLL, 9'h000);
    send_item(btq_pkg::MODE_POLL, 9'h1FF);
    send_sample(9'h0AA);
    send_sample(9'h155);
    repeat (5) send_poll();

    for (int n = 0; n < 215; n++) begin
      quiet = ((n / 40) % 3) == 1;
      if (n == 100) begin
        // wrap one button's counters with a long toggle run
        b = $urandom_range(0, NB - 1);
        for (int k = 0; k < 2 * (1 << CW) + 1; k++) begin
          levels[b] = ~levels[b];
          send_sample(levels);
        end
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_poll();
      end else if (r < 72) begin
        levels[$urandom_range(0, KW - 1)] ^= 1'b1;
        send_sample(levels);
      end else if (r < 88) begin
        send_sample(levels ^ KW'($urandom_range(0, 511) & $urandom_range(0, 511)));
      end else begin
        send_sample(KW'($urandom_range(0, 511)));
      end
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
